// ===== hdl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// AT response parser package
// Shared constants and transaction types for the AT response parser.
// ----------------------------------------------------------------------------
package arp_pkg;

  // Line store geometry.
  localparam int LINE_SIZE = 64;
  localparam int MAX_LINES = 32;

  localparam int STORE_DEPTH = MAX_LINES * LINE_SIZE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CPOS_W      = $clog2(LINE_SIZE);
  localparam int CNT_W       = $clog2(MAX_LINES + 1);

  // Request kinds.
  localparam logic REQ_FEED = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_NOT_READY = 2'd0;
  localparam logic [1:0] ST_OK        = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;
  localparam logic [1:0] ST_SYNTAX    = 2'd3;

  // Character constants.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_PRINT_LO = 8'd30;
  localparam logic [7:0] CH_PRINT_HI = 8'd127;

  typedef struct packed {
    logic       req_type;
    logic [7:0] character;
    logic [4:0] read_line;
    logic [5:0] read_col;
  } arp_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [5:0] lines_stored;
  } arp_rsp_t;

endpackage

// ===== hdl/arp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module arp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/at_response_parser.sv =====
// ----------------------------------------------------------------------------
// AT response parser
// Checks CR LF framing of modem AT responses and stores response text lines.
// ----------------------------------------------------------------------------
// Each request transaction (one received character, or one read of a stored
// byte) gives exactly one response transaction. A request is taken in every
// cycle while the response register is empty or being drained, so the block
// sustains one transaction per clock; the response is valid in the cycle after
// acceptance. The rate is set by the single-port line store: each transaction
// does at most one access to it (a text byte write or a byte read), and read
// data comes from the store's registered read port. The 2048-byte store has
// no clearing pass; a byte must be written before it is read back.
module at_response_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  arp_pkg::arp_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output arp_pkg::arp_rsp_t rsp_o
);
  import arp_pkg::*;

  localparam logic [4:0] P_CR0           = 5'd0;
  localparam logic [4:0] P_LF0           = 5'd1;
  localparam logic [4:0] P_FIRST         = 5'd2;
  localparam logic [4:0] P_OK_K          = 5'd3;
  localparam logic [4:0] P_OK_CR         = 5'd4;
  localparam logic [4:0] P_OK_LF         = 5'd5;
  localparam logic [4:0] P_E_R1          = 5'd6;
  localparam logic [4:0] P_E_R2          = 5'd7;
  localparam logic [4:0] P_E_O           = 5'd8;
  localparam logic [4:0] P_E_R3          = 5'd9;
  localparam logic [4:0] P_E_CR          = 5'd10;
  localparam logic [4:0] P_E_LF          = 5'd11;
  localparam logic [4:0] P_PLUS_FIRST    = 5'd12;
  localparam logic [4:0] P_PLUS_TEXT     = 5'd13;
  localparam logic [4:0] P_PLUS_LF       = 5'd14;
  localparam logic [4:0] P_PLUS_NEXT     = 5'd15;
  localparam logic [4:0] P_PLUS_BLANK_LF = 5'd16;
  localparam logic [4:0] P_PLUS_FINAL    = 5'd17;
  localparam logic [4:0] P_TEXT          = 5'd18;
  localparam logic [4:0] P_TEXT_LF       = 5'd19;
  localparam logic [4:0] P_TEXT_CR2      = 5'd20;
  localparam logic [4:0] P_TEXT_LF2      = 5'd21;
  localparam logic [4:0] P_TEXT_FINAL    = 5'd22;

  logic [4:0]        state_q, state_d;
  logic [CPOS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic        rsp_valid_q;
  logic [1:0]  status_q;
  logic [5:0]  lines_q;
  logic        rd_sel_q;

  logic        accept;
  logic        feed;
  logic        rd_req;
  logic        rd_in_range;
  logic        append;
  logic        end_line;
  logic        not_full;
  logic        wr_en;
  logic [7:0]  c;
  logic [1:0]  status_d;
  logic [CPOS_W-1:0] wr_col;
  logic [7:0]  wr_data;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]  ram_rdata;
  logic        printable;

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign feed        = accept && (req_i.req_type == REQ_FEED);
  assign rd_req      = accept && (req_i.req_type == REQ_READ);
  assign c           = req_i.character;
  assign printable   = (c > CH_PRINT_LO) && (c < CH_PRINT_HI);
  assign not_full    = cnt_q < CNT_W'(MAX_LINES);

  // Parser transition; a syntax error leaves the state where it is.
  always_comb begin
    state_d  = state_q;
    status_d = ST_NOT_READY;
    append   = 1'b0;
    end_line = 1'b0;
    unique case (state_q) inside
      P_LF0: begin
        if (c == CH_LF) state_d = P_FIRST; else status_d = ST_SYNTAX;
      end
      P_FIRST: begin
        if (c == CH_PLUS) begin
          state_d = P_PLUS_FIRST;
        end else if (c == CH_O) begin
          state_d = P_OK_K;
        end else if (c == CH_E) begin
          state_d = P_E_R1;
        end else if (printable) begin
          append  = 1'b1;
          state_d = P_TEXT;
        end else begin
          status_d = ST_SYNTAX;
        end
      end
      P_OK_K: begin
        if (c == CH_K) state_d = P_OK_CR; else status_d = ST_SYNTAX;
      end
      P_OK_CR: begin
        if (c == CH_CR) state_d = P_OK_LF; else status_d = ST_SYNTAX;
      end
      P_OK_LF: begin
        if (c == CH_LF) begin
          state_d  = P_CR0;
          status_d = ST_OK;
        end else begin
          status_d = ST_SYNTAX;
        end
      end
      P_E_R1: begin
        if (c == CH_R) state_d = P_E_R2; else status_d = ST_SYNTAX;
      end
      P_E_R2: begin
        if (c == CH_R) state_d = P_E_O; else status_d = ST_SYNTAX;
      end
      P_E_O: begin
        if (c == CH_O) state_d = P_E_R3; else status_d = ST_SYNTAX;
      end
      P_E_R3: begin
        if (c == CH_R) state_d = P_E_CR; else status_d = ST_SYNTAX;
      end
      P_E_CR: begin
        if (c == CH_CR) state_d = P_E_LF; else status_d = ST_SYNTAX;
      end
      P_E_LF: begin
        if (c == CH_LF) begin
          state_d  = P_CR0;
          status_d = ST_ERROR;
        end else begin
          status_d = ST_SYNTAX;
        end
      end
      P_PLUS_FIRST: begin
        if (c == CH_LF) begin
          status_d = ST_SYNTAX;
        end else begin
          append  = 1'b1;
          state_d = P_PLUS_TEXT;
        end
      end
      P_PLUS_TEXT: begin
        if (c == CH_CR) begin
          end_line = 1'b1;
          state_d  = P_PLUS_LF;
        end else if (c == CH_LF) begin
          status_d = ST_SYNTAX;
        end else begin
          append = 1'b1;
        end
      end
      P_PLUS_LF: begin
        if (c == CH_LF) state_d = P_PLUS_NEXT; else status_d = ST_SYNTAX;
      end
      P_PLUS_NEXT: begin
        if (c == CH_PLUS) begin
          state_d = P_PLUS_FIRST;
        end else if (c == CH_CR) begin
          state_d = P_PLUS_BLANK_LF;
        end else begin
          status_d = ST_SYNTAX;
        end
      end
      P_PLUS_BLANK_LF: begin
        if (c == CH_LF) state_d = P_PLUS_FINAL; else status_d = ST_SYNTAX;
      end
      P_PLUS_FINAL, P_TEXT_FINAL: begin
        if (c == CH_O) begin
          state_d = P_OK_K;
        end else if (c == CH_E) begin
          state_d = P_E_R1;
        end else begin
          status_d = ST_SYNTAX;
        end
      end
      P_TEXT: begin
        if (c == CH_CR) begin
          end_line = 1'b1;
          state_d  = P_TEXT_LF;
        end else if (printable) begin
          append = 1'b1;
        end else begin
          status_d = ST_SYNTAX;
        end
      end
      P_TEXT_LF: begin
        if (c == CH_LF) state_d = P_TEXT_CR2; else status_d = ST_SYNTAX;
      end
      P_TEXT_CR2: begin
        if (c == CH_CR) state_d = P_TEXT_LF2; else status_d = ST_SYNTAX;
      end
      P_TEXT_LF2: begin
        if (c == CH_LF) state_d = P_TEXT_FINAL; else status_d = ST_SYNTAX;
      end
      default: begin
        if (c == CH_CR) state_d = P_LF0; else status_d = ST_SYNTAX;
      end
    endcase
  end

  // Line position, line count and the store write that goes with them.
  always_comb begin
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    wr_col  = pos_q;
    wr_data = c;
    if (append) begin
      if (pos_q < CPOS_W'(LINE_SIZE - 1)) begin
        pos_d = pos_q + CPOS_W'(1);
      end else begin
        // Long line: extra text is dropped and the last byte keeps the terminator.
        wr_col  = CPOS_W'(LINE_SIZE - 1);
        wr_data = 8'd0;
      end
    end else if (end_line) begin
      wr_data = 8'd0;
      pos_d   = '0;
      if (not_full) cnt_d = cnt_q + CNT_W'(1);
    end else if (state_q == P_PLUS_TEXT && c == CH_LF) begin
      // A LF inside a '+' line is an error but still restarts the line position.
      pos_d = '0;
    end
  end

  assign wr_en   = feed && (append || end_line) && not_full;
  assign wr_addr = ADDR_W'(ADDR_W'(ROW_W'(cnt_q)) * ADDR_W'(LINE_SIZE)) + ADDR_W'(wr_col);
  assign rd_addr = ADDR_W'(ADDR_W'(ROW_W'(req_i.read_line)) * ADDR_W'(LINE_SIZE))
                 + ADDR_W'(req_i.read_col);
  assign rd_in_range = (int'(req_i.read_line) < MAX_LINES)
                    && (int'(req_i.read_col) < LINE_SIZE);
  assign ram_addr = wr_en ? wr_addr : rd_addr;

  arp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (rd_req),
    .addr_i  (ram_addr),
    .wdata_i (wr_data),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_CR0;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else if (feed) begin
      if (status_d != ST_SYNTAX) state_q <= state_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      rsp_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= feed ? status_d : ST_NOT_READY;
      lines_q  <= 6'(feed ? cnt_d : cnt_q);
      rd_sel_q <= rd_req && rd_in_range;
    end
  end

  assign rsp_valid_o        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.read_data    = rd_sel_q ? ram_rdata : 8'd0;
  assign rsp_o.lines_stored = lines_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_LINES))
    else $error("line count exceeds the store size");

  a_syntax_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    feed && status_d == ST_SYNTAX |=> $stable(state_q) && $stable(cnt_q))
    else $error("syntax error changed the parser state");

  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 cnt_q >= $past(cnt_q))
    else $error("line count decreased");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> cnt_q < CNT_W'(MAX_LINES))
    else $error("store written while full");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CPOS_W'(LINE_SIZE - 1))
    else $error("line position beyond the line size");

endmodule
